>>> rtl/core/msgpack_token_encoder_assert.svh
// Assertion macros for the token encoder checker.
`ifndef MSGPACK_TOKEN_ENCODER_ASSERT_SVH
`define MSGPACK_TOKEN_ENCODER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MTE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define MTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mte_pkg.sv
package mte_pkg;

    typedef enum logic [2:0] {
        REQ_NIL   = 3'd0,
        REQ_BOOL  = 3'd1,
        REQ_SINT  = 3'd2,
        REQ_UINT  = 3'd3,
        REQ_STR   = 3'd4,
        REQ_ARRAY = 3'd5,
        REQ_FLT   = 3'd6,
        REQ_BYTE  = 3'd7
    } t_req_type;

    // Number of big-endian value bytes that follow the marker.
    typedef enum logic [2:0] {
        NSEL_0 = 3'd0,
        NSEL_1 = 3'd1,
        NSEL_2 = 3'd2,
        NSEL_4 = 3'd3,
        NSEL_8 = 3'd4
    } t_nsel;

    localparam logic [7:0] MK_NIL     = 8'hC0;
    localparam logic [7:0] MK_FALSE   = 8'hC2;
    localparam logic [7:0] MK_TRUE    = 8'hC3;
    localparam logic [7:0] MK_BIN8    = 8'hC4;
    localparam logic [7:0] MK_BIN16   = 8'hC5;
    localparam logic [7:0] MK_BIN32   = 8'hC6;
    localparam logic [7:0] MK_FLOAT64 = 8'hCB;
    localparam logic [7:0] MK_UINT8   = 8'hCC;
    localparam logic [7:0] MK_UINT16  = 8'hCD;
    localparam logic [7:0] MK_UINT32  = 8'hCE;
    localparam logic [7:0] MK_UINT64  = 8'hCF;
    localparam logic [7:0] MK_INT8    = 8'hD0;
    localparam logic [7:0] MK_INT16   = 8'hD1;
    localparam logic [7:0] MK_INT32   = 8'hD2;
    localparam logic [7:0] MK_INT64   = 8'hD3;
    localparam logic [7:0] MK_FIXSTR  = 8'hA0;
    localparam logic [7:0] MK_STR8    = 8'hD9;
    localparam logic [7:0] MK_STR16   = 8'hDA;
    localparam logic [7:0] MK_STR32   = 8'hDB;
    localparam logic [7:0] MK_FIXARR  = 8'h90;
    localparam logic [7:0] MK_ARR16   = 8'hDC;
    localparam logic [7:0] MK_ARR32   = 8'hDD;
    localparam logic [7:0] MK_BIN_TAG = 8'h03;

    typedef struct packed {
        logic u_7f;       // value <= 0x7F
        logic u_ff;       // value <= 0xFF
        logic u_ffff;     // value <= 0xFFFF
        logic u_32;       // value fits in 32 bits
        logic neg_e0;     // value >= -32
        logic neg_80;     // value >= -128
        logic neg_8000;   // value >= -32768
        logic neg_32;     // value >= -2^31
        logic l_0f;       // length <= 15
        logic l_1f;       // length <= 31
        logic l_ff;       // length <= 0xFF
        logic l_ffff;     // length <= 0xFFFF
        logic l1_ff;      // saturated length + 1 <= 0xFF
        logic l1_ffff;    // saturated length + 1 <= 0xFFFF
    } t_flags;

    typedef struct packed {
        t_req_type   req_type;
        logic [63:0] value;
        logic [31:0] length;
        logic [31:0] len_inc;
        logic        is_name;
        logic [7:0]  data_byte;
        t_flags      flags;
    } t_s1;

    typedef struct packed {
        logic [7:0]  hdr;
        t_nsel       nsel;
        logic [63:0] word;
        logic        trailer;
    } t_s2;

    typedef struct packed {
        logic [71:0] bytes;   // left aligned, first byte in the top lane
        logic [3:0]  cnt;     // 1 to 9 bytes
    } t_s3;

endpackage

>>> rtl/core/mte_classify.sv
module mte_classify (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_value,
    input  logic [31:0] i_length,
    input  logic        i_is_name,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    output mte_pkg::t_s1 o_beat,
    input  logic        i_ready
);
    import mte_pkg::*;

    logic   r_valid;
    t_s1    r_beat;
    t_s1    n_beat;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_comb begin
        n_beat.req_type  = t_req_type'(i_req_type);
        n_beat.value     = i_value;
        n_beat.length    = i_length;
        n_beat.len_inc   = (i_length == 32'hFFFF_FFFF) ? i_length : i_length + 32'd1;
        n_beat.is_name   = i_is_name;
        n_beat.data_byte = i_data_byte;

        n_beat.flags.u_7f     = (i_value[63:7] == '0);
        n_beat.flags.u_ff     = (i_value[63:8] == '0);
        n_beat.flags.u_ffff   = (i_value[63:16] == '0);
        n_beat.flags.u_32     = (i_value[63:32] == '0);
        n_beat.flags.neg_e0   = (i_value[63:5] == '1);
        n_beat.flags.neg_80   = (i_value[63:7] == '1);
        n_beat.flags.neg_8000 = (i_value[63:15] == '1);
        n_beat.flags.neg_32   = (i_value[63:31] == '1);
        n_beat.flags.l_0f     = (i_length[31:4] == '0);
        n_beat.flags.l_1f     = (i_length[31:5] == '0);
        n_beat.flags.l_ff     = (i_length[31:8] == '0);
        n_beat.flags.l_ffff   = (i_length[31:16] == '0);
        n_beat.flags.l1_ff    = (i_length[31:8] == '0) && (i_length[7:0] != 8'hFF);
        n_beat.flags.l1_ffff  = (i_length[31:16] == '0) && (i_length[15:0] != 16'hFFFF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

endmodule

>>> rtl/core/mte_select.sv
module mte_select (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  mte_pkg::t_s1 i_beat,
    output logic         o_valid,
    output mte_pkg::t_s2 o_beat,
    input  logic         i_ready
);
    import mte_pkg::*;

    logic   r_valid;
    t_s2    r_beat;
    t_s2    n_beat;
    t_flags f;
    logic   use_unsigned;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;
    assign f       = i_beat.flags;

    always_comb begin
        n_beat.hdr     = MK_NIL;
        n_beat.nsel    = NSEL_0;
        n_beat.word    = i_beat.value;
        n_beat.trailer = 1'b0;
        use_unsigned   = 1'b0;

        unique case (i_beat.req_type)
            REQ_NIL: begin
                n_beat.hdr = MK_NIL;
            end
            REQ_BOOL: begin
                n_beat.hdr = i_beat.value[0] ? MK_TRUE : MK_FALSE;
            end
            REQ_SINT: begin
                if (!i_beat.value[63]) begin
                    use_unsigned = 1'b1;
                end else if (f.neg_e0) begin
                    n_beat.hdr = i_beat.value[7:0];
                end else if (f.neg_80) begin
                    n_beat.hdr  = MK_INT8;
                    n_beat.nsel = NSEL_1;
                end else if (f.neg_8000) begin
                    n_beat.hdr  = MK_INT16;
                    n_beat.nsel = NSEL_2;
                end else if (f.neg_32) begin
                    n_beat.hdr  = MK_INT32;
                    n_beat.nsel = NSEL_4;
                end else begin
                    n_beat.hdr  = MK_INT64;
                    n_beat.nsel = NSEL_8;
                end
            end
            REQ_UINT: begin
                use_unsigned = 1'b1;
            end
            REQ_STR: begin
                if (i_beat.is_name) begin
                    n_beat.word = {32'd0, i_beat.length};
                    if (f.l_1f) begin
                        n_beat.hdr = MK_FIXSTR | {3'd0, i_beat.length[4:0]};
                    end else if (f.l_ff) begin
                        n_beat.hdr  = MK_STR8;
                        n_beat.nsel = NSEL_1;
                    end else if (f.l_ffff) begin
                        n_beat.hdr  = MK_STR16;
                        n_beat.nsel = NSEL_2;
                    end else begin
                        n_beat.hdr  = MK_STR32;
                        n_beat.nsel = NSEL_4;
                    end
                end else begin
                    n_beat.word    = {32'd0, i_beat.len_inc};
                    n_beat.trailer = 1'b1;
                    if (f.l1_ff) begin
                        n_beat.hdr  = MK_BIN8;
                        n_beat.nsel = NSEL_1;
                    end else if (f.l1_ffff) begin
                        n_beat.hdr  = MK_BIN16;
                        n_beat.nsel = NSEL_2;
                    end else begin
                        n_beat.hdr  = MK_BIN32;
                        n_beat.nsel = NSEL_4;
                    end
                end
            end
            REQ_ARRAY: begin
                n_beat.word = {32'd0, i_beat.length};
                if (f.l_0f) begin
                    n_beat.hdr = MK_FIXARR | {4'd0, i_beat.length[3:0]};
                end else if (f.l_ffff) begin
                    n_beat.hdr  = MK_ARR16;
                    n_beat.nsel = NSEL_2;
                end else begin
                    n_beat.hdr  = MK_ARR32;
                    n_beat.nsel = NSEL_4;
                end
            end
            REQ_FLT: begin
                n_beat.hdr  = MK_FLOAT64;
                n_beat.nsel = NSEL_8;
            end
            REQ_BYTE: begin
                n_beat.hdr = i_beat.data_byte;
            end
        endcase

        if (use_unsigned) begin
            if (f.u_7f) begin
                n_beat.hdr = i_beat.value[7:0];
            end else if (f.u_ff) begin
                n_beat.hdr  = MK_UINT8;
                n_beat.nsel = NSEL_1;
            end else if (f.u_ffff) begin
                n_beat.hdr  = MK_UINT16;
                n_beat.nsel = NSEL_2;
            end else if (f.u_32) begin
                n_beat.hdr  = MK_UINT32;
                n_beat.nsel = NSEL_4;
            end else begin
                n_beat.hdr  = MK_UINT64;
                n_beat.nsel = NSEL_8;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

endmodule

>>> rtl/core/mte_format.sv
module mte_format (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  mte_pkg::t_s2 i_beat,
    output logic         o_valid,
    output mte_pkg::t_s3 o_beat,
    input  logic         i_ready
);
    import mte_pkg::*;

    logic        r_valid;
    t_s3         r_beat;
    t_s3         n_beat;
    logic [63:0] aligned;
    logic [63:0] w;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;
    assign w       = i_beat.word;

    // Left align the value bytes under the marker; a bin header gets its
    // type byte right after the length.
    always_comb begin
        aligned = '0;
        n_beat.cnt = 4'd1;
        unique case (i_beat.nsel)
            NSEL_0: begin
                aligned    = '0;
                n_beat.cnt = 4'd1;
            end
            NSEL_1: begin
                aligned    = i_beat.trailer ? {w[7:0], MK_BIN_TAG, 48'd0} : {w[7:0], 56'd0};
                n_beat.cnt = i_beat.trailer ? 4'd3 : 4'd2;
            end
            NSEL_2: begin
                aligned    = i_beat.trailer ? {w[15:0], MK_BIN_TAG, 40'd0} : {w[15:0], 48'd0};
                n_beat.cnt = i_beat.trailer ? 4'd4 : 4'd3;
            end
            NSEL_4: begin
                aligned    = i_beat.trailer ? {w[31:0], MK_BIN_TAG, 24'd0} : {w[31:0], 32'd0};
                n_beat.cnt = i_beat.trailer ? 4'd6 : 4'd5;
            end
            NSEL_8: begin
                aligned    = w;
                n_beat.cnt = 4'd9;
            end
            default: begin
                aligned    = '0;
                n_beat.cnt = 4'd1;
            end
        endcase
        n_beat.bytes = {i_beat.hdr, aligned};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= n_beat;
        end
    end

endmodule

>>> rtl/core/mte_serialize.sv
module mte_serialize (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  mte_pkg::t_s3 i_beat,
    output logic         o_valid,
    output logic [7:0]   o_out_byte,
    output logic         o_last,
    input  logic         i_stall
);
    import mte_pkg::*;

    logic        r_valid;
    logic        r_last;
    logic [71:0] r_buf;
    logic [3:0]  r_cnt;
    logic        out_fire;

    assign out_fire   = r_valid && !i_stall;
    // Take the next token when empty or as the last byte leaves.
    assign o_ready    = !r_valid || (out_fire && r_last);
    assign o_valid    = r_valid;
    assign o_out_byte = r_buf[71:64];
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_buf  <= i_beat.bytes;
            r_cnt  <= i_beat.cnt;
            r_last <= (i_beat.cnt == 4'd1);
        end else if (out_fire && !r_last) begin
            r_buf  <= {r_buf[63:0], 8'd0};
            r_cnt  <= r_cnt - 4'd1;
            r_last <= (r_cnt == 4'd2);
        end
    end

endmodule

>>> rtl/core/msgpack_token_encoder.sv
// MessagePack token encoder. Each input beat carries one token (nil, bool,
// signed or unsigned integer, float64, string header, array header or one
// payload byte) and produces its MessagePack encoding as a run of output
// beats, one byte per beat, most significant byte first, with o_last set on
// the final byte of the token. Integers take the smallest fixint, uint or int
// form. A name string (i_is_name high) gets a plain str header; a value string
// gets a bin header over length plus one (saturating at 0xFFFFFFFF) followed
// by the type byte 0x03. Only headers are emitted for strings and arrays; the
// caller sends the string bytes as payload-byte tokens and the elements as
// tokens of their own. A token leaves as one output beat per byte, 1 to 9
// bytes in all; the byte serializer at the end of the pipe shifts them out,
// so payload bytes and other one-byte tokens stream at one beat per cycle
// while i_stall is low. An accepted token passes the classify, select,
// format and serialize registers in that order before its first byte shows
// on the output. The block keeps no state between tokens and has no
// configuration.
module msgpack_token_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_value,
    input  logic [31:0] i_length,
    input  logic        i_is_name,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);
    import mte_pkg::*;

    logic s1_ready;
    logic s1_valid;
    t_s1  s1_beat;
    logic s2_ready;
    logic s2_valid;
    t_s2  s2_beat;
    logic s3_ready;
    logic s3_valid;
    t_s3  s3_beat;
    logic s4_ready;

    // Hold the input side whenever the first stage cannot advance.
    assign o_stall = !s1_ready;

    // Stage 1: register the token with its range compares and length + 1.
    mte_classify u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (s1_ready),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_length    (i_length),
        .i_is_name   (i_is_name),
        .i_data_byte (i_data_byte),
        .o_valid     (s1_valid),
        .o_beat      (s1_beat),
        .i_ready     (s2_ready)
    );

    // Stage 2: pick the marker byte and how many value bytes follow.
    mte_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s2_ready),
        .i_beat  (s1_beat),
        .o_valid (s2_valid),
        .o_beat  (s2_beat),
        .i_ready (s3_ready)
    );

    // Stage 3: pack marker, value bytes and bin type byte into one word.
    mte_format u_format (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s3_ready),
        .i_beat  (s2_beat),
        .o_valid (s3_valid),
        .o_beat  (s3_beat),
        .i_ready (s4_ready)
    );

    // Stage 4: shift the word out a byte per beat; it doubles as the
    // output register, so the pipe keeps filling while a byte waits.
    mte_serialize u_serialize (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s3_valid),
        .o_ready    (s4_ready),
        .i_beat     (s3_beat),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_last     (o_last),
        .i_stall    (i_stall)
    );

endmodule

>>> rtl/core/mte_checker.sv
`include "msgpack_token_encoder_assert.svh"

module mte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [2:0]  i_req_type,
    input logic [63:0] i_value,
    input logic [31:0] i_length,
    input logic        i_is_name,
    input logic [7:0]  i_data_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_last
);

    logic         out_fire;
    logic [107:0] in_payload;

    assign out_fire   = o_valid && !i_stall;
    assign in_payload = {i_req_type, i_value, i_length, i_is_name, i_data_byte};

    // A stalled output beat holds its byte and its last flag.
    `MTE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_byte) && $stable(o_last), "output beat changed while stalled")

    // A token that is not finished keeps the output valid for its next byte.
    `MTE_ASSERT_NEXT(a_token_continues, i_clk, i_rst_n, out_fire && !o_last, o_valid, "token ended without a last byte")

    // An empty output stage never pushes back on the input.
    `MTE_ASSERT_IMPLY(a_no_stall_when_empty, i_clk, i_rst_n, !o_valid, !o_stall, "input stalled while output empty")

    // A stalled input beat stays valid and holds its fields.
    `MTE_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(in_payload), "input beat changed while stalled")

endmodule

bind msgpack_token_encoder mte_checker u_mte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_req_type  (i_req_type),
    .i_value     (i_value),
    .i_length    (i_length),
    .i_is_name   (i_is_name),
    .i_data_byte (i_data_byte),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last)
);
